>>> rtl/group_membership_table_core_defines.svh
// Assertion macros shared by the membership table modules.
`ifndef GROUP_MEMBERSHIP_TABLE_CORE_DEFINES_SVH
`define GROUP_MEMBERSHIP_TABLE_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define GMT_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define GMT_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/gmt_pkg.sv
// Types and constants of the group membership table.
package gmt_pkg;

	localparam int ADDR_W  = 32;
	localparam int GROUP_W = 16;

	localparam logic [GROUP_W-1:0] GRP_ONE = 16'h0001;

	localparam logic OP_REGISTER = 1'b0;
	localparam logic OP_DELETE   = 1'b1;

	typedef struct packed {
		logic               operation;
		logic [ADDR_W-1:0]  client_address;
		logic [GROUP_W-1:0] group_mask;
	} gmt_req_t;

	typedef struct packed {
		logic               success;
		logic [GROUP_W-1:0] changed_groups;
		logic [GROUP_W-1:0] full_groups;
	} gmt_rsp_t;

	typedef struct packed {
		logic load;
		logic add;
		logic rd;
		logic cmp;
		logic grp_end;
	} gmt_cmd_t;

	typedef struct packed {
		logic slot_done;
		logic grp_last;
	} gmt_stat_t;

endpackage

>>> rtl/group_membership_table_core.sv
// Top level of the multicast group membership table.
// Usage:
//   A request (operation, client_address, group_mask in req) is taken at a rising
//   edge where start is high and busy is low. busy stays high until the result
//   has been shown. The result (success, changed_groups, full_groups in rsp) is
//   valid for exactly one cycle while done is high; the receiver cannot stall it.
// Sequence, from the accepting edge to the cycle in which done is high:
//   register: groups 0 to min(N_GROUPS, 16) - 1 are visited, one group row per
//             cycle, the address appended to each selected row that has room.
//   delete:   every group is walked; every stored entry of every row is read
//             once through the single read port, with a read and then a compare
//             for each, a hit compacting the row on the way.
//   A new request may be taken in the cycle after done.
// Reset clears every group count and returns the sequencer to idle; the member
// rows themselves are not cleared, since only entries below a count are read.
module group_membership_table_core import gmt_pkg::*; #(
	parameter int N_GROUPS          = 16,
	parameter int MEMBERS_PER_GROUP = 16
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  gmt_req_t req,
	output logic     done,
	output gmt_rsp_t rsp
);

	gmt_cmd_t  cmd;
	gmt_stat_t stat;

	gmt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.operation (req.operation),
		.stat      (stat),
		.cmd       (cmd),
		.busy      (busy),
		.done      (done)
	);

	gmt_datapath #(
		.N_GROUPS          (N_GROUPS),
		.MEMBERS_PER_GROUP (MEMBERS_PER_GROUP)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.stat   (stat),
		.rsp    (rsp)
	);

endmodule

>>> rtl/gmt_ctrl.sv
// Sequencer of the membership table: walks groups and slots for one request.
`include "group_membership_table_core_defines.svh"

module gmt_ctrl import gmt_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  logic      operation,
	input  gmt_stat_t stat,
	output gmt_cmd_t  cmd,
	output logic      busy,
	output logic      done
);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_ADD  = 5'b00010,
		ST_DCHK = 5'b00100,
		ST_DCMP = 5'b01000,
		ST_DONE = 5'b10000
	} gmt_state_t;

	gmt_state_t state_q, state_d;
	logic       accept;

	assign busy   = (state_q != ST_IDLE);
	assign done   = (state_q == ST_DONE);
	assign accept = start && !busy;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = (operation == OP_DELETE) ? ST_DCHK : ST_ADD;
				end
			end
			ST_ADD: begin
				cmd.add = 1'b1;
				if (stat.grp_last) state_d = ST_DONE;
			end
			ST_DCHK: begin
				if (stat.slot_done) begin
					cmd.grp_end = 1'b1;
					if (stat.grp_last) state_d = ST_DONE;
				end else begin
					cmd.rd  = 1'b1;
					state_d = ST_DCMP;
				end
			end
			ST_DCMP: begin
				cmd.cmp = 1'b1;
				state_d = ST_DCHK;
			end
			ST_DONE: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	`GMT_ASSERT_NXT(a_accept_busy, accept, busy, "accepted request did not raise busy")
	`GMT_ASSERT_NXT(a_done_idle, done, !busy && !done, "result strobe not followed by idle")

endmodule

>>> rtl/gmt_datapath.sv
// Member rows, per-group counts and result flags of the membership table.
`include "group_membership_table_core_defines.svh"

module gmt_datapath import gmt_pkg::*; #(
	parameter int N_GROUPS          = 16,
	parameter int MEMBERS_PER_GROUP = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	input  gmt_req_t  req,
	input  gmt_cmd_t  cmd,
	output gmt_stat_t stat,
	output gmt_rsp_t  rsp
);

	localparam int GW         = (N_GROUPS > 1) ? $clog2(N_GROUPS) : 1;
	localparam int SW         = (MEMBERS_PER_GROUP > 1) ? $clog2(MEMBERS_PER_GROUP) : 1;
	localparam int CW         = $clog2(MEMBERS_PER_GROUP + 1);
	localparam int AW         = GW + SW;
	localparam int DEPTH      = N_GROUPS * (2 ** SW);
	localparam int ADD_GROUPS = (N_GROUPS < GROUP_W) ? N_GROUPS : GROUP_W;

	logic [ADDR_W-1:0] mem [DEPTH];

	logic               op_q;
	logic [ADDR_W-1:0]  addr_q;
	logic [GROUP_W-1:0] mask_q;
	logic [GW-1:0]      grp_q;
	logic [CW-1:0]      slot_q;
	logic               found_q;
	logic               any_q;
	logic [GROUP_W-1:0] changed_q;
	logic [GROUP_W-1:0] full_q;
	logic [CW-1:0]      cnt_q [N_GROUPS];
	logic [ADDR_W-1:0]  rd_data_q;

	logic [CW-1:0]      cur_cnt;
	logic [CW-1:0]      slot_prev;
	logic               row_full;
	logic [GROUP_W-1:0] grp_bit;
	logic [GROUP_W-1:0] mask_sh;
	logic               sel;
	logic               hit;
	logic               append;
	logic               we;
	logic [AW-1:0]      wa;
	logic [ADDR_W-1:0]  wd;
	logic [AW-1:0]      ra;

	assign cur_cnt   = cnt_q[grp_q];
	assign slot_prev = slot_q - CW'(1);
	assign row_full  = (cur_cnt == CW'(MEMBERS_PER_GROUP));
	assign grp_bit   = GRP_ONE << grp_q;
	assign mask_sh   = mask_q >> grp_q;
	assign sel       = mask_sh[0];
	assign hit       = (rd_data_q == addr_q);
	assign append    = cmd.add && sel && !row_full;

	// Append at the row tail, or move a later entry up one slot behind a hit.
	assign we = append || (cmd.cmp && found_q);
	assign wa = cmd.add ? {grp_q, cur_cnt[SW-1:0]} : {grp_q, slot_prev[SW-1:0]};
	assign wd = cmd.add ? addr_q : rd_data_q;
	assign ra = {grp_q, slot_q[SW-1:0]};

	always_ff @(posedge clk) begin
		if (we) mem[wa] <= wd;
		if (cmd.rd) rd_data_q <= mem[ra];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= req.operation;
			addr_q <= req.client_address;
			mask_q <= req.group_mask;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grp_q     <= '0;
			slot_q    <= '0;
			found_q   <= 1'b0;
			any_q     <= 1'b0;
			changed_q <= '0;
			full_q    <= '0;
			for (int g = 0; g < N_GROUPS; g++) begin
				cnt_q[g] <= '0;
			end
		end else begin
			if (cmd.load) begin
				grp_q     <= '0;
				slot_q    <= '0;
				found_q   <= 1'b0;
				any_q     <= 1'b0;
				changed_q <= '0;
				full_q    <= '0;
			end
			if (cmd.add) begin
				if (sel && row_full) full_q <= full_q | grp_bit;
				if (append) begin
					cnt_q[grp_q] <= cur_cnt + CW'(1);
					changed_q    <= changed_q | grp_bit;
				end
				grp_q <= grp_q + GW'(1);
			end
			if (cmd.cmp) begin
				if (hit) found_q <= 1'b1;
				slot_q <= slot_q + CW'(1);
			end
			// Close the row: shrink it if an entry was dropped, then advance.
			if (cmd.grp_end) begin
				if (found_q) begin
					cnt_q[grp_q] <= cur_cnt - CW'(1);
					changed_q    <= changed_q | grp_bit;
					any_q        <= 1'b1;
				end
				grp_q   <= grp_q + GW'(1);
				slot_q  <= '0;
				found_q <= 1'b0;
			end
		end
	end

	assign stat.slot_done = (slot_q == cur_cnt);
	assign stat.grp_last  = (op_q == OP_DELETE) ? (grp_q == GW'(N_GROUPS - 1))
	                                            : (grp_q == GW'(ADD_GROUPS - 1));

	assign rsp.success        = (op_q == OP_DELETE) ? any_q : (full_q == '0);
	assign rsp.changed_groups = changed_q;
	assign rsp.full_groups    = full_q;

	`GMT_ASSERT_IMP(a_shift_behind_hit, cmd.cmp && found_q, slot_q != '0, "shift into slot below zero")
	`GMT_ASSERT_IMP(a_cnt_bound, cmd.add || cmd.rd, cur_cnt <= CW'(MEMBERS_PER_GROUP), "row count beyond row size")

endmodule
